>>> hdl/mced_pkg.sv
// Package for the multi-channel event debounce block.
// Holds the shared types, register indexes, result codes and defaults.
// No dependencies.
package mced_pkg;

  // Fixed field widths.
  localparam int CH_W   = 4;
  localparam int PS_W   = 3;
  localparam int REG_W  = 8;
  localparam int HOLD_W = 8;
  localparam int IDX_REG_W = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_CHANNELS  = 10;
  localparam int DEF_COUNTER_WIDTH = 8;

  // Reset values of the configuration registers.
  localparam logic [REG_W-1:0]  RST_DEBOUNCE = 8'd10;
  localparam logic [HOLD_W-1:0] RST_HOLD     = 8'd40;

  // Channels with a debounce time of their own.
  localparam logic [CH_W-1:0] PWR_BTN_CH = 4'd0;
  localparam logic [CH_W-1:0] ADAPTER_CH = 4'd1;
  localparam logic [CH_W-1:0] BATTERY_CH = 4'd2;

  // Configuration register indexes.
  typedef enum logic [IDX_REG_W-1:0] {
    REG_PB_DEBOUNCE  = 3'd0,
    REG_AD_DEBOUNCE  = 3'd1,
    REG_BAT_DEBOUNCE = 3'd2,
    REG_EXT_DEBOUNCE = 3'd3,
    REG_HOLD_TIMEOUT = 3'd4
  } reg_idx_t;

  // Event kinds.
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  // Sleep states as sampled.
  localparam logic [PS_W-1:0] PS_S3 = 3'd1;
  localparam logic [PS_W-1:0] PS_S4 = 3'd2;
  localparam logic [PS_W-1:0] PS_S5 = 3'd3;

  // Wake request codes.
  localparam logic [1:0] WAKE_NONE = 2'd0;
  localparam logic [1:0] WAKE_S5   = 2'd1;
  localparam logic [1:0] WAKE_S4   = 2'd2;
  localparam logic [1:0] WAKE_S3   = 2'd3;

  // Configuration register bundle.
  typedef struct packed {
    logic [REG_W-1:0]  pb_debounce;
    logic [REG_W-1:0]  ad_debounce;
    logic [REG_W-1:0]  bat_debounce;
    logic [REG_W-1:0]  ext_debounce;
    logic [HOLD_W-1:0] hold_timeout;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [CH_W-1:0] event_channel;
    kind_t           event_kind;
    logic [1:0]      wake_request;
    logic            hold_expired;
    logic            stable_level;
    logic            debouncing;
  } result_t;

  // Wake request for a committed power button press.
  function automatic logic [1:0] wake_code(input logic [PS_W-1:0] ps);
    logic [1:0] code;
    code = WAKE_NONE;
    if (ps == PS_S5) code = WAKE_S5;
    else if (ps == PS_S4) code = WAKE_S4;
    else if (ps == PS_S3) code = WAKE_S3;
    return code;
  endfunction

endpackage

>>> hdl/multi_channel_event_debounce.sv
// Top level of the multi-channel event debounce block.
// Depends on mced_pkg, mced_cfg_regs, mced_state_mem and mced_update.
//
// Channel   Handshake              Payload
// -------   --------------------   --------------------------------------------
// input     in_valid / in_ready    channel, level, power_state
// output    out_valid / out_ready  event_channel, event_kind, wake_request,
//                                  hold_expired, stable_level, debouncing
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The state memory is read at the edge that accepts a sample. The update and
// write-back run in the update stage, whose result is registered as it advances.
// A new sample is accepted every cycle unless the output stalls; a read of the entry
// being written on the same edge takes the written value, which keeps that rate.
// Reset is synchronous; the entry valid bits clear all channel state at once.
// A stalled output holds one result and one more sample in the update stage.
module multi_channel_event_debounce
  import mced_pkg::*;
#(
  parameter int NUM_CHANNELS  = DEF_NUM_CHANNELS,
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CH_W-1:0]      channel,
  input  logic                 level,
  input  logic [PS_W-1:0]      power_state,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      event_channel,
  output logic [1:0]           event_kind,
  output logic [1:0]           wake_request,
  output logic                 hold_expired,
  output logic                 stable_level,
  output logic                 debouncing,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_REG_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ENT_W = COUNTER_WIDTH + 1;

  cfg_t              cfg;
  logic              in_accept;
  logic              in_range;
  logic              s1_valid;
  logic              s1_advance;
  logic              s1_in_range;
  logic [CH_W-1:0]   s1_channel;
  logic              s1_level;
  logic [PS_W-1:0]   s1_power_state;
  logic [ENT_W-1:0]  rd_data;
  logic [ENT_W-1:0]  ent_next;
  logic [HOLD_W-1:0] hold;
  logic [HOLD_W-1:0] hold_next;
  logic              wr_en;
  result_t           res_next;
  result_t           res;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  mced_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input handshake and stage advance.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;
  assign in_range   = ({1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS));
  assign wr_en      = s1_advance && s1_in_range;

  mced_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ENT_W        (ENT_W),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept && in_range),
    .rd_addr (channel[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_channel[IDX_W-1:0]),
    .wr_data (ent_next)
  );

  // Update stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Update stage payload, captured with the memory read.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_channel     <= channel;
      s1_level       <= level;
      s1_power_state <= power_state;
      s1_in_range    <= in_range;
    end
  end

  mced_update #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_upd (
    .cfg         (cfg),
    .in_range    (s1_in_range),
    .channel     (s1_channel),
    .level       (s1_level),
    .power_state (s1_power_state),
    .ent         (rd_data),
    .hold        (hold),
    .ent_next    (ent_next),
    .hold_next   (hold_next),
    .res         (res_next)
  );

  // Hold countdown of the power button.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (s1_advance) begin
      hold <= hold_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= res_next;
    end
  end

  assign event_channel = res.event_channel;
  assign event_kind    = res.event_kind;
  assign wake_request  = res.wake_request;
  assign hold_expired  = res.hold_expired;
  assign stable_level  = res.stable_level;
  assign debouncing    = res.debouncing;

`ifndef SYNTHESIS
  // A hold timeout only comes from a steady power button sample.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && hold_expired |->
      event_channel == PWR_BTN_CH && event_kind == KIND_NONE && stable_level)
    else $error("hold timeout outside a steady power button press");

  // A wake request only comes with a committed power button press.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_request != WAKE_NONE |->
      event_channel == PWR_BTN_CH && event_kind == KIND_PRESS)
    else $error("wake request without a power button press");

  // A committed change ends a running debounce and matches the new level.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != KIND_NONE |->
      debouncing && (stable_level == (event_kind == KIND_PRESS)))
    else $error("committed event inconsistent with debounce state");

  // Input back-pressure only when both stages are full and the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> hdl/mced_cfg_regs.sv
// Configuration register file of the event debounce block.
// Depends on mced_pkg for the register indexes and the bundle type.
module mced_cfg_regs
  import mced_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IDX_REG_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pb_debounce  <= RST_DEBOUNCE;
      cfg.ad_debounce  <= RST_DEBOUNCE;
      cfg.bat_debounce <= RST_DEBOUNCE;
      cfg.ext_debounce <= RST_DEBOUNCE;
      cfg.hold_timeout <= RST_HOLD;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PB_DEBOUNCE:  cfg.pb_debounce  <= wr_data;
        REG_AD_DEBOUNCE:  cfg.ad_debounce  <= wr_data;
        REG_BAT_DEBOUNCE: cfg.bat_debounce <= wr_data;
        REG_EXT_DEBOUNCE: cfg.ext_debounce <= wr_data;
        REG_HOLD_TIMEOUT: cfg.hold_timeout <= HOLD_W'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/mced_state_mem.sv
// Per-channel state memory: stable level and debounce counter of each channel.
// Synchronous read with write-first bypass; valid bits give the reset value.
module mced_state_mem #(
  parameter int NUM_CHANNELS = 10,
  parameter int ENT_W        = 9,
  parameter int IDX_W        = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ENT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data
);

  logic [ENT_W-1:0]        mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] entry_valid;

  // Entry valid bits, cleared at reset so unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same entry on the same edge is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (entry_valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

>>> hdl/mced_update.sv
// Read-modify-write update of one channel's debounce state and the hold countdown.
// Depends on mced_pkg for the result codes and the bundle types.
module mced_update
  import mced_pkg::*;
#(
  parameter int COUNTER_WIDTH = 8
) (
  input  cfg_t                     cfg,
  input  logic                     in_range,
  input  logic [CH_W-1:0]          channel,
  input  logic                     level,
  input  logic [PS_W-1:0]          power_state,
  input  logic [COUNTER_WIDTH:0]   ent,
  input  logic [HOLD_W-1:0]        hold,
  output logic [COUNTER_WIDTH:0]   ent_next,
  output logic [HOLD_W-1:0]        hold_next,
  output result_t                  res
);

  logic                     stable;
  logic [COUNTER_WIDTH-1:0] cnt;
  logic [COUNTER_WIDTH-1:0] cnt_next;
  logic                     stable_next;
  logic [REG_W-1:0]         deb_time;

  assign stable = ent[COUNTER_WIDTH];
  assign cnt    = ent[COUNTER_WIDTH-1:0];

  // Debounce time of the sampled channel.
  always_comb begin
    priority if (channel == PWR_BTN_CH) deb_time = cfg.pb_debounce;
    else if (channel == ADAPTER_CH) deb_time = cfg.ad_debounce;
    else if (channel == BATTERY_CH) deb_time = cfg.bat_debounce;
    else deb_time = cfg.ext_debounce;
  end

  // Counter, stable level, hold countdown and result fields.
  always_comb begin
    cnt_next              = cnt;
    stable_next           = stable;
    hold_next             = hold;
    res                   = '0;
    res.event_channel     = channel;
    res.event_kind        = KIND_NONE;
    if (in_range) begin
      res.debouncing = (cnt != '0);
      if (level != stable) begin
        if (cnt == '0) begin
          cnt_next = COUNTER_WIDTH'(deb_time);
        end else begin
          cnt_next = cnt - COUNTER_WIDTH'(1);
          if (cnt == COUNTER_WIDTH'(1)) begin
            stable_next = level;
            if (level) begin
              res.event_kind = KIND_PRESS;
              if (channel == PWR_BTN_CH) begin
                hold_next        = cfg.hold_timeout;
                res.wake_request = wake_code(power_state);
              end
            end else begin
              res.event_kind = KIND_RELEASE;
            end
          end
        end
      end else if (channel == PWR_BTN_CH && stable && hold != '0) begin
        hold_next        = hold - HOLD_W'(1);
        res.hold_expired = (hold == HOLD_W'(1));
      end
      res.stable_level = stable_next;
    end
  end

  assign ent_next = {stable_next, cnt_next};

endmodule

>>> dv/multi_channel_event_debounce_tb.sv
`timescale 1ns / 1ps
// Testbench for multi_channel_event_debounce: a directed table, then random sample
// bursts under several idle patterns, checked by a debounce predictor or typed rows.
// Depends on mced_pkg and the multi_channel_event_debounce RTL.
module multi_channel_event_debounce_tb;
  import mced_pkg::*;

  localparam int NUM_CH          = DEF_NUM_CHANNELS;
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_GAP         = 20;
  localparam int MAX_REPORTS     = 20;
  localparam int PHASE_ITEMS     = 70;

  // Sleep states that the package leaves unnamed.
  localparam logic [PS_W-1:0] PS_S0    = 3'd0;
  localparam logic [PS_W-1:0] PS_OTHER = 3'd4;

  localparam result_t NO_RESULT = '0;

  // One row of the directed table: a register write or a sample transaction.
  typedef struct packed {
    logic             is_cfg;
    reg_idx_t         idx;
    logic [REG_W-1:0] data;
    logic [CH_W-1:0]  ch;
    logic             lv;
    logic [PS_W-1:0]  ps;
    logic             typed;
    result_t          want;
  } stim_row_t;

  localparam int N_ROWS = 33;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // Straight after reset: a quiet channel, out-of-range channels, a first edge.
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd3, 1'b0, PS_S0, 1'b1,
      '{4'd3, KIND_NONE, WAKE_NONE, 1'b0, 1'b0, 1'b0}},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd15, 1'b1, 3'd7, 1'b1,
      '{4'd15, KIND_NONE, WAKE_NONE, 1'b0, 1'b0, 1'b0}},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd10, 1'b1, PS_OTHER, 1'b1,
      '{4'd10, KIND_NONE, WAKE_NONE, 1'b0, 1'b0, 1'b0}},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd9, 1'b1, 3'd5, 1'b1,
      '{4'd9, KIND_NONE, WAKE_NONE, 1'b0, 1'b0, 1'b0}},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd9, 1'b1, 3'd6, 1'b0, NO_RESULT},
    // Short times, external debounce apart, so that edges commit in a few samples.
    '{1'b1, REG_PB_DEBOUNCE,  8'd1,   4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b1, REG_AD_DEBOUNCE,  8'd1,   4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b1, REG_BAT_DEBOUNCE, 8'd2,   4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b1, REG_EXT_DEBOUNCE, 8'd255, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b1, REG_HOLD_TIMEOUT, 8'd2,   4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    // Press from S5, hold countdown to expiry, bounce during release.
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S5, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S5, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, 3'd7, 1'b0, NO_RESULT},
    // Press from S4, then release.
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S4, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S4, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    // Press from S3 with a zero hold timeout: the countdown never runs.
    '{1'b1, REG_HOLD_TIMEOUT, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S3, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_S3, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b1, PS_OTHER, 1'b0, NO_RESULT},
    // Zero debounce time: the power button can no longer be released.
    '{1'b1, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd0, 1'b0, PS_S0, 1'b0, NO_RESULT},
    // Battery insert with its own time, then the wide external and adapter loads.
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd2, 1'b1, 3'd5, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd2, 1'b1, 3'd5, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd2, 1'b1, 3'd5, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd8, 1'b1, PS_S0, 1'b0, NO_RESULT},
    '{1'b0, REG_PB_DEBOUNCE, 8'd0, 4'd1, 1'b1, PS_S0, 1'b0, NO_RESULT}
  };

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      channel     = '0;
  logic                 level       = 1'b0;
  logic [PS_W-1:0]      power_state = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [CH_W-1:0]      event_channel;
  logic [1:0]           event_kind;
  logic [1:0]           wake_request;
  logic                 hold_expired;
  logic                 stable_level;
  logic                 debouncing;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [IDX_REG_W-1:0] cfg_index   = '0;
  logic [REG_W-1:0]     cfg_data    = '0;

  // Predictor state and its copy of the configuration.
  logic              stable_lvl [NUM_CH];
  logic [REG_W-1:0]  dbc_cnt [NUM_CH];
  logic [HOLD_W-1:0] hold_left;
  cfg_t              shadow_cfg;

  result_t expected_q [$];
  result_t got_result;
  result_t want_result;
  int      errors          = 0;
  int      send_idle_pct   = 0;
  int      recv_stall_pct  = 0;
  int      hold_off_asks   = 0;
  int      hold_off_served = 0;
  int      hold_off_left   = 0;

  multi_channel_event_debounce uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Debounce time that a channel loads on its first differing sample.
  function automatic logic [REG_W-1:0] debounce_time_of(input logic [CH_W-1:0] ch);
    logic [REG_W-1:0] t;
    case (ch)
      PWR_BTN_CH: t = shadow_cfg.pb_debounce;
      ADAPTER_CH: t = shadow_cfg.ad_debounce;
      BATTERY_CH: t = shadow_cfg.bat_debounce;
      default:    t = shadow_cfg.ext_debounce;
    endcase
    return t;
  endfunction

  // Advances the predictor by one sample and returns the result it causes.
  function automatic result_t debounce_predict(input logic [CH_W-1:0] ch, input logic lv,
                                               input logic [PS_W-1:0] ps);
    result_t r;
    r = NO_RESULT;
    r.event_channel = ch;
    if (ch >= NUM_CH) return r;
    r.debouncing = (dbc_cnt[ch] != '0);
    if (lv != stable_lvl[ch]) begin
      if (dbc_cnt[ch] == '0) begin
        dbc_cnt[ch] = debounce_time_of(ch);
      end else begin
        dbc_cnt[ch] = dbc_cnt[ch] - 1'b1;
        if (dbc_cnt[ch] == '0) begin
          stable_lvl[ch] = lv;
          if (lv) begin
            r.event_kind = KIND_PRESS;
            if (ch == PWR_BTN_CH) begin
              hold_left = shadow_cfg.hold_timeout;
              case (ps)
                PS_S5:   r.wake_request = WAKE_S5;
                PS_S4:   r.wake_request = WAKE_S4;
                PS_S3:   r.wake_request = WAKE_S3;
                default: r.wake_request = WAKE_NONE;
              endcase
            end
          end else begin
            r.event_kind = KIND_RELEASE;
          end
        end
      end
    end else if (ch == PWR_BTN_CH && stable_lvl[ch] && hold_left != '0) begin
      hold_left = hold_left - 1'b1;
      r.hold_expired = (hold_left == '0);
    end
    r.stable_level = stable_lvl[ch];
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off_asks != hold_off_served) begin
      hold_off_served = hold_off_served + 1;
      hold_off_left   = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Every accepted result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got_result.event_channel = event_channel;
      got_result.event_kind    = kind_t'(event_kind);
      got_result.wake_request  = wake_request;
      got_result.hold_expired  = hold_expired;
      got_result.stable_level  = stable_level;
      got_result.debouncing    = debouncing;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected, ch=%0d kind=%0d",
                   $time, event_channel, event_kind);
      end else begin
        want_result = expected_q.pop_front();
        if (got_result !== want_result) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"%0t: mismatch, expected ch=%0d kind=%0d wake=%0d expired=%0b ",
                      "stable=%0b busy=%0b, actual ch=%0d kind=%0d wake=%0d expired=%0b ",
                      "stable=%0b busy=%0b"}, $time,
                     want_result.event_channel, want_result.event_kind,
                     want_result.wake_request, want_result.hold_expired,
                     want_result.stable_level, want_result.debouncing,
                     event_channel, event_kind, wake_request, hold_expired,
                     stable_level, debouncing);
        end
      end
    end
  end

  // Offers one sample transaction, after a random gap, and records its expectation.
  task automatic drive_sample(input logic [CH_W-1:0] ch, input logic lv,
                              input logic [PS_W-1:0] ps, input logic typed,
                              input result_t want);
    int gap;
    result_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    channel     <= ch;
    level       <= lv;
    power_state <= ps;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = debounce_predict(ch, lv, ps);
    expected_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stops offering samples and waits until every result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write transaction; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PB_DEBOUNCE:  shadow_cfg.pb_debounce  = data;
      REG_AD_DEBOUNCE:  shadow_cfg.ad_debounce  = data;
      REG_BAT_DEBOUNCE: shadow_cfg.bat_debounce = data;
      REG_EXT_DEBOUNCE: shadow_cfg.ext_debounce = data;
      REG_HOLD_TIMEOUT: shadow_cfg.hold_timeout = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [REG_W-1:0] pb, input logic [REG_W-1:0] ad,
                          input logic [REG_W-1:0] bat, input logic [REG_W-1:0] ext,
                          input logic [REG_W-1:0] hold);
    drain_results();
    write_reg(REG_PB_DEBOUNCE, pb);
    write_reg(REG_AD_DEBOUNCE, ad);
    write_reg(REG_BAT_DEBOUNCE, bat);
    write_reg(REG_EXT_DEBOUNCE, ext);
    write_reg(REG_HOLD_TIMEOUT, hold);
    cfg_valid <= 1'b0;
  endtask

  // Mostly bursts of one level on one channel, long enough to commit unless capped,
  // with occasional bounces inside a burst and stray samples on any channel.
  task automatic run_bursts(input int n_items, input int len_cap);
    int sent;
    int len;
    int ch;
    logic target;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9, 0) == 0) begin
        drive_sample(CH_W'($urandom_range(15, 0)), 1'($urandom_range(1, 0)),
                     PS_W'($urandom_range(7, 0)), 1'b0, NO_RESULT);
        sent++;
      end else begin
        ch = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(NUM_CH - 1, 0);
        target = ($urandom_range(4, 0) == 0) ? 1'($urandom_range(1, 0)) : ~stable_lvl[ch];
        len = int'(debounce_time_of(CH_W'(ch))) + 1 + $urandom_range(2, 0);
        if (len > len_cap) len = len_cap;
        repeat (len) begin
          drive_sample(CH_W'(ch), ($urandom_range(9, 0) == 0) ? ~target : target,
                       PS_W'($urandom_range(7, 0)), 1'b0, NO_RESULT);
          sent++;
        end
        // Keep the power button down for the hold countdown to run out, within the cap.
        if (ch == 0 && target == 1'b1 && $urandom_range(1, 0) == 1) begin
          len = int'(shadow_cfg.hold_timeout) + 1;
          if (len > len_cap) len = len_cap;
          repeat (len) begin
            drive_sample(PWR_BTN_CH, 1'b1, PS_W'($urandom_range(7, 0)), 1'b0, NO_RESULT);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    foreach (stable_lvl[i]) begin
      stable_lvl[i] = 1'b0;
      dbc_cnt[i]    = '0;
    end
    hold_left  = '0;
    shadow_cfg = '{RST_DEBOUNCE, RST_DEBOUNCE, RST_DEBOUNCE, RST_DEBOUNCE, RST_HOLD};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; register writes only once the block has drained.
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        if (r == 0 || !DIRECTED[r - 1].is_cfg) drain_results();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
        if (r == N_ROWS - 1 || !DIRECTED[r + 1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        drive_sample(DIRECTED[r].ch, DIRECTED[r].lv, DIRECTED[r].ps, DIRECTED[r].typed,
                     DIRECTED[r].want);
      end
    end

    // Settings of one, no idling on either side.
    set_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_bursts(PHASE_ITEMS, 40);

    // Sender mostly idle.
    set_regs(REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(10, 1)));
    send_idle_pct  = 69;
    recv_stall_pct = 0;
    run_bursts(PHASE_ITEMS, 40);

    // Receiver mostly stalled.
    set_regs(REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(10, 1)));
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    run_bursts(PHASE_ITEMS, 40);

    // Highest settings, light idling on both sides.
    set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_bursts(PHASE_ITEMS, 40);

    // Long receiver hold-off while samples keep coming, so the input backs up.
    set_regs(REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(6, 1)), REG_W'($urandom_range(6, 1)),
             REG_W'($urandom_range(10, 1)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_asks  = hold_off_asks + 1;
    run_bursts(PHASE_ITEMS, 40);

    // Small settings that include zero debounce and hold times.
    set_regs(REG_W'($urandom_range(4, 0)), REG_W'($urandom_range(4, 0)),
             REG_W'($urandom_range(4, 0)), REG_W'($urandom_range(4, 0)),
             REG_W'($urandom_range(4, 0)));
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_bursts(PHASE_ITEMS, 40);

    drain_results();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mced_pkg.sv
hdl/mced_cfg_regs.sv
hdl/mced_state_mem.sv
hdl/mced_update.sv
hdl/multi_channel_event_debounce.sv
dv/multi_channel_event_debounce_tb.sv
